@@ rtl/ptpd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared widths, constants, types and helpers of the point transform unit.
// ----------------------------------------------------------------------------
package ptpd_pkg;

   localparam int DATA_W  = 32;
   localparam int IDX_W   = 4;
   localparam int EPS_W   = 16;
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int VAL_W   = ACC_W - FRAC_W + 1;
   localparam int QUO_W   = DATA_W;
   localparam int FIX_ONE = 65536;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_WORD_LSB = 2;

   localparam logic CSR_IDX_EPSILON = 1'b0;
   localparam logic CMD_LOAD        = 1'b0;
   localparam logic CMD_XFORM       = 1'b1;

   localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

   localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

   // matrix column of a sequencer step
   localparam logic [1:0] COL_X = 2'd0;
   localparam logic [1:0] COL_Y = 2'd1;
   localparam logic [1:0] COL_Z = 2'd2;
   localparam logic [1:0] COL_T = 2'd3;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [VAL_W-1:0]  val_type;
   typedef logic [VAL_W-1:0]         mag_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } clamp_type;

   function automatic logic [DATA_W-1:0] identity_elem(logic [IDX_W-1:0] idx);
      logic [DATA_W-1:0] e;
      begin
         e = (idx[3:2] == idx[1:0]) ? DATA_W'(FIX_ONE) : '0;
         return e;
      end
   endfunction

   function automatic mag_type mag_of(val_type v);
      mag_type m;
      begin
         m = v[VAL_W-1] ? mag_type'(-v) : mag_type'(v);
         return m;
      end
   endfunction

   function automatic clamp_type clamp32(val_type v);
      clamp_type c;
      begin
         if (!v[VAL_W-1] && (|v[VAL_W-2:DATA_W-1])) begin
            c.value = S32_MAX;
            c.sat   = 1'b1;
         end else if (v[VAL_W-1] && !(&v[VAL_W-2:DATA_W-1])) begin
            c.value = S32_MIN;
            c.sat   = 1'b1;
         end else begin
            c.value = v[DATA_W-1:0];
            c.sat   = 1'b0;
         end
         return c;
      end
   endfunction

endpackage

@@ rtl/ptpd_matrix_mem.sv @@
// ----------------------------------------------------------------------------
// ptpd_matrix_mem
// 16 x 32 matrix store, registered read; unwritten entries read as identity.
// ----------------------------------------------------------------------------
module ptpd_matrix_mem (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [ptpd_pkg::IDX_W-1:0]     wr_addr,
   input  logic [ptpd_pkg::DATA_W-1:0]    wr_data,
   input  logic [ptpd_pkg::IDX_W-1:0]     rd_addr,
   output logic [ptpd_pkg::DATA_W-1:0]    rd_data
);

   localparam int DEPTH = 2 ** ptpd_pkg::IDX_W;

   logic [ptpd_pkg::DATA_W-1:0] mem_ff [DEPTH];
   logic [ptpd_pkg::DATA_W-1:0] rd_word_ff;
   logic [ptpd_pkg::IDX_W-1:0]  rd_addr_ff;
   logic [DEPTH-1:0]            valid_ff;
   logic [DEPTH-1:0]            valid_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_word_ff <= mem_ff[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = valid_ff[rd_addr_ff] ? rd_word_ff : ptpd_pkg::identity_elem(rd_addr_ff);

endmodule

@@ rtl/ptpd_dot_engine.sv @@
// ----------------------------------------------------------------------------
// ptpd_dot_engine
// Walks the matrix store and forms x, y, z, w on one shared multiplier.
// ----------------------------------------------------------------------------
module ptpd_dot_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  ptpd_pkg::word_type            pt_x,
   input  ptpd_pkg::word_type            pt_y,
   input  ptpd_pkg::word_type            pt_z,
   output logic [ptpd_pkg::IDX_W-1:0]    rd_addr,
   input  logic [ptpd_pkg::DATA_W-1:0]   rd_data,
   output logic                          done,
   output ptpd_pkg::val_type             row_val [4]
);

   logic                               issue_ff;
   logic [ptpd_pkg::IDX_W-1:0]         step_ff;
   logic                               s1_vld_ff;
   logic [ptpd_pkg::IDX_W-1:0]         s1_step_ff;
   logic                               s2_vld_ff;
   logic [ptpd_pkg::IDX_W-1:0]         s2_step_ff;
   logic                               done_ff;
   ptpd_pkg::word_type                 pt_ff [3];
   logic signed [ptpd_pkg::PROD_W-1:0] prod_ff;
   logic signed [ptpd_pkg::PROD_W-1:0] prod_in;
   logic signed [ptpd_pkg::ACC_W-1:0]  acc_ff;
   logic signed [ptpd_pkg::ACC_W-1:0]  acc_sum;
   ptpd_pkg::val_type                  v_ff [4];
   ptpd_pkg::word_type                 elem;
   ptpd_pkg::word_type                 op_pt;
   logic [1:0]                         k1;
   logic [1:0]                         k2;
   logic [1:0]                         r2;

   // element index = column * 4 + row
   assign rd_addr = {step_ff[1:0], step_ff[3:2]};

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= 1'b0;
         step_ff   <= '0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         if (start) begin
            issue_ff <= 1'b1;
            step_ff  <= '0;
         end else if (issue_ff) begin
            step_ff <= step_ff + 1'b1;
            if (&step_ff) begin
               issue_ff <= 1'b0;
            end
         end
         s1_vld_ff <= issue_ff;
         s2_vld_ff <= s1_vld_ff;
         done_ff   <= s2_vld_ff && (k2 == ptpd_pkg::COL_T) && (&r2);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pt_ff[0] <= pt_x;
         pt_ff[1] <= pt_y;
         pt_ff[2] <= pt_z;
      end
      s1_step_ff <= step_ff;
      s2_step_ff <= s1_step_ff;
   end

   // stage 1: multiply, or pass the translation term
   assign k1   = s1_step_ff[1:0];
   assign elem = ptpd_pkg::word_type'(rd_data);

   always_comb begin
      case (k1)
         ptpd_pkg::COL_X: op_pt = pt_ff[0];
         ptpd_pkg::COL_Y: op_pt = pt_ff[1];
         default:         op_pt = pt_ff[2];
      endcase
      if (k1 == ptpd_pkg::COL_T) begin
         prod_in = ptpd_pkg::PROD_W'(elem);
      end else begin
         prod_in = elem * op_pt;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // stage 2: accumulate exactly, floor to Q16.16 and add translation
   assign k2      = s2_step_ff[1:0];
   assign r2      = s2_step_ff[3:2];
   assign acc_sum = acc_ff + ptpd_pkg::ACC_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (s2_vld_ff) begin
         case (k2) inside
            ptpd_pkg::COL_X: acc_ff <= ptpd_pkg::ACC_W'(prod_ff);
            ptpd_pkg::COL_Y, ptpd_pkg::COL_Z: acc_ff <= acc_sum;
            ptpd_pkg::COL_T: v_ff[r2] <= ptpd_pkg::VAL_W'(acc_ff >>> ptpd_pkg::FRAC_W)
                                        + prod_ff[ptpd_pkg::VAL_W-1:0];
            default: ;
         endcase
      end
   end

   assign done    = done_ff;
   assign row_val = v_ff;

endmodule

@@ rtl/ptpd_divider.sv @@
// ----------------------------------------------------------------------------
// ptpd_divider
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
module ptpd_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  ptpd_pkg::val_type   num [3],
   input  ptpd_pkg::val_type   den,
   output logic                done,
   output ptpd_pkg::word_type  quo [3],
   output logic                sat
);

   localparam int VW    = ptpd_pkg::VAL_W;
   localparam int QW    = ptpd_pkg::QUO_W;
   localparam int FW    = ptpd_pkg::FRAC_W;
   localparam int CNT_W = $clog2(QW);

   logic                 init_ff;
   logic                 run_ff;
   logic                 fin_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   ptpd_pkg::mag_type    da_ff;
   logic                 den_neg_ff;
   ptpd_pkg::mag_type    na_ff  [3];
   logic                 neg_ff [3];
   logic                 ovf_ff [3];
   ptpd_pkg::mag_type    rem_ff [3];
   logic [QW-1:0]        sh_ff  [3];
   logic [QW-1:0]        q_ff   [3];
   ptpd_pkg::word_type   quo_ff [3];
   logic                 sat_ff;
   logic [VW:0]          trial  [3];
   logic [VW:0]          diff   [3];
   ptpd_pkg::word_type   lane_res [3];
   logic [2:0]           lane_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= 1'b0;
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         init_ff <= start;
         fin_ff  <= run_ff && (&cnt_ff);
         done_ff <= fin_ff;
         if (init_ff) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (&cnt_ff) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         da_ff      <= ptpd_pkg::mag_of(den);
         den_neg_ff <= den[VW-1];
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      assign trial[g] = {rem_ff[g], sh_ff[g][QW-1]};
      assign diff[g]  = trial[g] - {1'b0, da_ff};

      always_ff @(posedge clock) begin
         if (start) begin
            na_ff[g]  <= ptpd_pkg::mag_of(num[g]);
            neg_ff[g] <= num[g][VW-1];
         end else if (init_ff) begin
            neg_ff[g] <= neg_ff[g] ^ den_neg_ff;
            ovf_ff[g] <= VW'(na_ff[g][VW-1:FW]) >= da_ff;
            rem_ff[g] <= VW'(na_ff[g][VW-1:FW]);
            sh_ff[g]  <= {na_ff[g][FW-1:0], {(QW-FW){1'b0}}};
            q_ff[g]   <= '0;
         end else if (run_ff) begin
            sh_ff[g] <= {sh_ff[g][QW-2:0], 1'b0};
            if (!diff[g][VW]) begin
               rem_ff[g] <= diff[g][VW-1:0];
               q_ff[g]   <= {q_ff[g][QW-2:0], 1'b1};
            end else begin
               rem_ff[g] <= trial[g][VW-1:0];
               q_ff[g]   <= {q_ff[g][QW-2:0], 1'b0};
            end
         end
      end

      always_comb begin
         if (ovf_ff[g]) begin
            lane_res[g] = neg_ff[g] ? ptpd_pkg::S32_MIN : ptpd_pkg::S32_MAX;
            lane_sat[g] = 1'b1;
         end else if (neg_ff[g]) begin
            if (q_ff[g] > ptpd_pkg::S32_MIN) begin
               lane_res[g] = ptpd_pkg::S32_MIN;
               lane_sat[g] = 1'b1;
            end else begin
               lane_res[g] = -q_ff[g];
               lane_sat[g] = 1'b0;
            end
         end else if (q_ff[g][QW-1]) begin
            lane_res[g] = ptpd_pkg::S32_MAX;
            lane_sat[g] = 1'b1;
         end else begin
            lane_res[g] = q_ff[g];
            lane_sat[g] = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (fin_ff) begin
            quo_ff[g] <= lane_res[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin_ff) begin
         sat_ff <= |lane_sat;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign sat  = sat_ff;

endmodule

@@ rtl/point_transform_perspective_divide_unit.sv @@
// ----------------------------------------------------------------------------
// point_transform_perspective_divide_unit
// 4x4 homogeneous point transform in Q16.16 with optional perspective divide.
// ----------------------------------------------------------------------------
// A load beat (cmd 0) writes one column-major matrix element in the cycle it
// is taken and the unit is ready again on the next cycle. A transform beat
// (cmd 1) passes the dot engine and, when x, y and z are divided by w, the
// divider before its result is valid: sixteen matrix reads feed one shared
// 32x32 multiplier, and the three quotients come from a restoring divider
// that yields one bit per cycle. One transform is in flight at a time; a
// finished result sits in the output register, so the next beat is taken
// while it waits. The matrix resets to identity and epsilon to 1; epsilon
// lives at byte address 0.
// ----------------------------------------------------------------------------
module point_transform_perspective_divide_unit (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_cmd,
   input  logic [ptpd_pkg::IDX_W-1:0]           req_elem_index,
   input  logic signed [ptpd_pkg::DATA_W-1:0]   req_elem_value,
   input  logic signed [ptpd_pkg::DATA_W-1:0]   req_px,
   input  logic signed [ptpd_pkg::DATA_W-1:0]   req_py,
   input  logic signed [ptpd_pkg::DATA_W-1:0]   req_pz,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ptpd_pkg::DATA_W-1:0]   rsp_ox,
   output logic signed [ptpd_pkg::DATA_W-1:0]   rsp_oy,
   output logic signed [ptpd_pkg::DATA_W-1:0]   rsp_oz,
   output logic                                 rsp_divided,
   output logic                                 rsp_saturated,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ptpd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ptpd_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [ptpd_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                 csr_pready
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DOT    = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   localparam int VW = ptpd_pkg::VAL_W;

   state_type                        state_ff;
   state_type                        state_in;
   logic [ptpd_pkg::EPS_W-1:0]       eps_ff;
   logic                             csr_wr;
   logic                             csr_hit;
   logic                             req_take;
   logic                             load_take;
   logic                             xform_take;
   logic [ptpd_pkg::IDX_W-1:0]       rd_addr;
   logic [ptpd_pkg::DATA_W-1:0]      rd_data;
   logic                             dot_done;
   ptpd_pkg::val_type                row_val [4];
   ptpd_pkg::val_type                div_num [3];
   logic                             div_start;
   logic                             div_done;
   ptpd_pkg::word_type               div_quo [3];
   logic                             div_sat;
   ptpd_pkg::mag_type                w_mag;
   logic signed [VW:0]               w_off;
   logic [VW:0]                      w_off_mag;
   logic                             div_cond;
   ptpd_pkg::clamp_type              clamp_res [3];
   ptpd_pkg::word_type               res_ff [3];
   logic                             res_div_ff;
   logic                             res_sat_ff;
   logic                             out_load;
   logic                             rsp_valid_ff;
   ptpd_pkg::word_type               rsp_ox_ff;
   ptpd_pkg::word_type               rsp_oy_ff;
   ptpd_pkg::word_type               rsp_oz_ff;
   logic                             rsp_div_ff;
   logic                             rsp_sat_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[ptpd_pkg::CSR_WORD_LSB] == ptpd_pkg::CSR_IDX_EPSILON;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? ptpd_pkg::DATA_W'(eps_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= ptpd_pkg::EPS_RESET;
      end else if (csr_wr && csr_hit) begin
         eps_ff <= csr_pwdata[ptpd_pkg::EPS_W-1:0];
      end
   end

   // input beat
   assign req_stall  = state_ff != ST_IDLE;
   assign req_take   = req_valid && !req_stall;
   assign load_take  = req_take && (req_cmd == ptpd_pkg::CMD_LOAD);
   assign xform_take = req_take && (req_cmd == ptpd_pkg::CMD_XFORM);

   ptpd_matrix_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_take),
      .wr_addr (req_elem_index),
      .wr_data (req_elem_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ptpd_dot_engine u_dot (
      .clock   (clock),
      .reset   (reset),
      .start   (xform_take),
      .pt_x    (req_px),
      .pt_y    (req_py),
      .pt_z    (req_pz),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .done    (dot_done),
      .row_val (row_val)
   );

   // w near zero or one: pass through with clamping
   assign w_mag     = ptpd_pkg::mag_of(row_val[3]);
   assign w_off     = (VW+1)'(row_val[3]) - (VW+1)'(ptpd_pkg::FIX_ONE);
   assign w_off_mag = w_off[VW] ? (VW+1)'(-w_off) : (VW+1)'(w_off);
   assign div_cond  = (row_val[3] != '0)
                      && !(w_mag < VW'(eps_ff))
                      && !(w_off_mag < (VW+1)'(eps_ff));
   assign div_start = (state_ff == ST_DECIDE) && div_cond;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         clamp_res[i] = ptpd_pkg::clamp32(row_val[i]);
      end
   end

   assign div_num[0] = row_val[0];
   assign div_num[1] = row_val[1];
   assign div_num[2] = row_val[2];

   ptpd_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (row_val[3]),
      .done  (div_done),
      .quo   (div_quo),
      .sat   (div_sat)
   );

   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (xform_take) state_in = ST_DOT;
         ST_DOT:    if (dot_done) state_in = ST_DECIDE;
         ST_DECIDE: state_in = div_cond ? ST_DIV : ST_OUT;
         ST_DIV:    if (div_done) state_in = ST_OUT;
         ST_OUT:    if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         res_div_ff <= div_cond;
         res_sat_ff <= clamp_res[0].sat | clamp_res[1].sat | clamp_res[2].sat;
         for (int i = 0; i < 3; i++) begin
            res_ff[i] <= clamp_res[i].value;
         end
      end else if ((state_ff == ST_DIV) && div_done) begin
         res_sat_ff <= div_sat;
         for (int i = 0; i < 3; i++) begin
            res_ff[i] <= div_quo[i];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ox_ff  <= res_ff[0];
         rsp_oy_ff  <= res_ff[1];
         rsp_oz_ff  <= res_ff[2];
         rsp_div_ff <= res_div_ff;
         rsp_sat_ff <= res_sat_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ox        = rsp_ox_ff;
   assign rsp_oy        = rsp_oy_ff;
   assign rsp_oz        = rsp_oz_ff;
   assign rsp_divided   = rsp_div_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

@@ sim/point_transform_perspective_divide_unit_tb.sv @@
// ----------------------------------------------------------------------------
// point_transform_perspective_divide_unit_tb
// Self-checking bench for the Q16.16 point transform and perspective divide.
// Matrix loads and point transforms go in over the valid/stall request
// channel; every transform beat is predicted from a local copy of the
// matrix and epsilon, and each result beat is checked against the oldest
// prediction. Epsilon is rewritten over the APB port between phases, and
// both ends idle and stall at random in different mixes.
// ----------------------------------------------------------------------------
module point_transform_perspective_divide_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int       CYCLE_LIMIT  = 1000000;
   localparam int       DRAIN_CYCLES = 80;
   localparam int       PHASE_BEATS  = 165;
   localparam ptpd_pkg::word_type ONE = ptpd_pkg::word_type'(ptpd_pkg::FIX_ONE);
   localparam logic [ptpd_pkg::CSR_ADDR_W-1:0] EPS_ADDR =
      ptpd_pkg::CSR_ADDR_W'(ptpd_pkg::CSR_IDX_EPSILON) << ptpd_pkg::CSR_WORD_LSB;

   typedef logic signed [79:0] sum_type;

   typedef struct {
      ptpd_pkg::word_type ox;
      ptpd_pkg::word_type oy;
      ptpd_pkg::word_type oz;
      logic               divided;
      logic               saturated;
   } point_result_type;

   class xform_scoreboard;
      localparam sum_type SUM_TOP = 80'sd2147483647;
      localparam sum_type SUM_BOT = -80'sd2147483648;

      ptpd_pkg::word_type mat[16];
      logic [15:0]        eps;
      point_result_type   pending_q[$];
      int                 fails;

      function new();
         for (int i = 0; i < 16; i++) begin
            mat[i] = (i / 4 == i % 4) ? ONE : '0;
         end
         eps   = ptpd_pkg::EPS_RESET;
         fails = 0;
      endfunction

      function void set_epsilon(logic [15:0] v);
         eps = v;
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fails++;
         end
      endfunction

      // exact sum of products, floored to Q16.16, plus translation
      function sum_type row_sum(int r, ptpd_pkg::word_type x, ptpd_pkg::word_type y,
                                ptpd_pkg::word_type z);
         sum_type acc;
         acc = mat[r] * x + mat[4 + r] * y + mat[8 + r] * z;
         acc = (acc >>> ptpd_pkg::FRAC_W) + mat[12 + r];
         return acc;
      endfunction

      function ptpd_pkg::word_type finish_coord(sum_type v, sum_type w, logic div,
                                                inout logic sat);
         logic [127:0]       na;
         logic [127:0]       da;
         logic [127:0]       mag;
         logic               neg;
         ptpd_pkg::word_type q;
         if (!div) begin
            if (v > SUM_TOP) begin
               sat = 1'b1;
               q   = ptpd_pkg::S32_MAX;
            end else if (v < SUM_BOT) begin
               sat = 1'b1;
               q   = ptpd_pkg::S32_MIN;
            end else begin
               q = v[31:0];
            end
            return q;
         end
         neg = (v < 0) != (w < 0);
         na  = (v < 0) ? -v : v;
         da  = (w < 0) ? -w : w;
         mag = (na << ptpd_pkg::FRAC_W) / da;
         if (neg) begin
            if (mag > 128'h8000_0000) begin
               sat = 1'b1;
               q   = ptpd_pkg::S32_MIN;
            end else begin
               q = -mag[31:0];
            end
         end else begin
            if (mag > 128'h7FFF_FFFF) begin
               sat = 1'b1;
               q   = ptpd_pkg::S32_MAX;
            end else begin
               q = mag[31:0];
            end
         end
         return q;
      endfunction

      function void note_beat(logic cmd, logic [3:0] idx, ptpd_pkg::word_type val,
                              ptpd_pkg::word_type px, ptpd_pkg::word_type py,
                              ptpd_pkg::word_type pz);
         sum_type          x, y, z, w, wd, w1, eps_s;
         logic             div;
         logic             sat;
         point_result_type e;
         if (cmd == ptpd_pkg::CMD_LOAD) begin
            mat[idx] = val;
            return;
         end
         x     = row_sum(0, px, py, pz);
         y     = row_sum(1, px, py, pz);
         z     = row_sum(2, px, py, pz);
         w     = row_sum(3, px, py, pz);
         eps_s = eps;
         wd    = (w < 0) ? -w : w;
         w1    = w - ptpd_pkg::FIX_ONE;
         if (w1 < 0) w1 = -w1;
         div   = (w != 0) && !(wd < eps_s) && !(w1 < eps_s);
         sat   = 1'b0;
         e.ox  = finish_coord(x, w, div, sat);
         e.oy  = finish_coord(y, w, div, sat);
         e.oz  = finish_coord(z, w, div, sat);
         e.divided   = div;
         e.saturated = sat;
         pending_q.push_back(e);
      endfunction

      function void check_result(ptpd_pkg::word_type ox, ptpd_pkg::word_type oy,
                                 ptpd_pkg::word_type oz, logic dv, logic st);
         point_result_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: result beat with no transform outstanding", $time);
            fails++;
            return;
         end
         e = pending_q.pop_front();
         compare_field("ox", e.ox, ox);
         compare_field("oy", e.oy, oy);
         compare_field("oz", e.oz, oz);
         compare_field("divided", 32'(e.divided), 32'(dv));
         compare_field("saturated", 32'(e.saturated), 32'(st));
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_cmd = ptpd_pkg::CMD_LOAD;
   logic [ptpd_pkg::IDX_W-1:0]      req_elem_index = '0;
   ptpd_pkg::word_type              req_elem_value = '0;
   ptpd_pkg::word_type              req_px = '0;
   ptpd_pkg::word_type              req_py = '0;
   ptpd_pkg::word_type              req_pz = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   ptpd_pkg::word_type              rsp_ox;
   ptpd_pkg::word_type              rsp_oy;
   ptpd_pkg::word_type              rsp_oz;
   logic                            rsp_divided;
   logic                            rsp_saturated;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [ptpd_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [ptpd_pkg::DATA_W-1:0]     csr_pwdata = '0;
   logic [ptpd_pkg::DATA_W-1:0]     csr_prdata;
   logic                            csr_pready;

   xform_scoreboard board = new();
   int              gap_pct = 0;
   int              stall_pct = 0;
   logic [15:0]     cur_eps = ptpd_pkg::EPS_RESET;
   int              cycles = 0;

   point_transform_perspective_divide_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_elem_index (req_elem_index),
      .req_elem_value (req_elem_value),
      .req_px         (req_px),
      .req_py         (req_py),
      .req_pz         (req_pz),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ox         (rsp_ox),
      .rsp_oy         (rsp_oy),
      .rsp_oz         (rsp_oz),
      .rsp_divided    (rsp_divided),
      .rsp_saturated  (rsp_saturated),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", CYCLE_LIMIT);
         $display("point_transform_perspective_divide_unit_tb: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_ox, rsp_oy, rsp_oz, rsp_divided, rsp_saturated);
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   function automatic ptpd_pkg::word_type pick_word();
      ptpd_pkg::word_type v;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: v = $signed($urandom_range(0, 1048576)) - 524288;
         6, 7:             v = $urandom;
         8: begin
            case ($urandom_range(6))
               0:       v = ptpd_pkg::S32_MIN;
               1:       v = ptpd_pkg::S32_MAX;
               2:       v = '0;
               3:       v = -1;
               4:       v = 1;
               5:       v = ONE;
               default: v = -ONE;
            endcase
         end
         default:          v = $signed($urandom_range(0, 64)) - 32;
      endcase
      return v;
   endfunction

   // w row: mostly zero in x/y/z so that m15 alone steers w near 0 and 1.0
   function automatic ptpd_pkg::word_type pick_elem(logic [3:0] idx);
      ptpd_pkg::word_type v;
      int                 off;
      off = $urandom_range(0, 2 * cur_eps + 4) - cur_eps - 2;
      if (idx == 4'd15) begin
         case ($urandom_range(5))
            0:       v = '0;
            1:       v = ONE;
            2:       v = ONE + off;
            3:       v = off;
            4:       v = $signed($urandom_range(0, 1048576)) - 524288;
            default: v = $urandom;
         endcase
      end else if (idx[1:0] == 2'd3) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: v = '0;
            6, 7, 8:          v = $signed($urandom_range(0, 262144)) - 131072;
            default:          v = $urandom;
         endcase
      end else begin
         v = pick_word();
      end
      return v;
   endfunction

   task automatic send_beat(logic cmd, logic [3:0] idx, ptpd_pkg::word_type val,
                            ptpd_pkg::word_type x, ptpd_pkg::word_type y,
                            ptpd_pkg::word_type z);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_elem_index <= idx;
      req_elem_value <= val;
      req_px         <= x;
      req_py         <= y;
      req_pz         <= z;
      do @(posedge clock); while (req_stall);
      board.note_beat(cmd, idx, val, x, y, z);
   endtask

   task automatic load_elem(logic [3:0] idx, ptpd_pkg::word_type val);
      send_beat(ptpd_pkg::CMD_LOAD, idx, val, $urandom, $urandom, $urandom);
   endtask

   task automatic xform_point(ptpd_pkg::word_type x, ptpd_pkg::word_type y,
                              ptpd_pkg::word_type z);
      send_beat(ptpd_pkg::CMD_XFORM, 4'($urandom), $urandom, x, y, z);
   endtask

   task automatic write_epsilon(logic [15:0] v);
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= EPS_ADDR;
      csr_pwdata  <= {16'($urandom), v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.set_epsilon(v);
      cur_eps = v;
      // read back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.compare_field("epsilon readback", 32'(v),
                          32'(csr_prdata[ptpd_pkg::EPS_W-1:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      logic [15:0] eps_plan[6];
      eps_plan = '{16'd1, 16'd0, 16'd65535, 16'($urandom_range(2, 65534)), 16'd1, 16'd300};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: identity, extremes, clamps, w at 0, near 1.0, tiny and negative
      xform_point(ptpd_pkg::S32_MIN, ptpd_pkg::S32_MAX, '0);
      xform_point(-1, 1, 3 * ONE);
      load_elem(4'd12, ptpd_pkg::S32_MAX);
      load_elem(4'd0, 1);
      xform_point(-1, 5, 7);
      xform_point(2 * ONE, '0, '0);
      load_elem(4'd0, ptpd_pkg::S32_MIN);
      load_elem(4'd12, ptpd_pkg::S32_MIN);
      xform_point(ptpd_pkg::S32_MAX, '0, '0);
      load_elem(4'd0, ONE);
      load_elem(4'd12, 1);
      load_elem(4'd15, -ONE);
      xform_point(ptpd_pkg::S32_MAX, ptpd_pkg::S32_MIN, '0);
      load_elem(4'd15, 2);
      xform_point(ONE, '0, 1);
      load_elem(4'd15, '0);
      xform_point(5, 6, 7);
      load_elem(4'd15, ONE + 1);
      xform_point(3 * ONE, -5 * ONE, 12345);
      load_elem(4'd15, 1);
      xform_point(1, 2, 3);
      load_elem(4'd3, ONE);
      load_elem(4'd15, '0);
      xform_point(-2 * ONE, 7 * ONE, -3);

      for (int p = 0; p < 6; p++) begin
         if (p > 0)
            write_epsilon(eps_plan[p]);
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 58; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 58; end
            default: begin gap_pct = 13; stall_pct = 13; end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            logic [3:0] idx;
            idx = $urandom;
            if ($urandom_range(99) < 25)
               load_elem(idx, pick_elem(idx));
            else
               xform_point(pick_word(), pick_word(), pick_word());
         end
      end

      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fails == 0)
         $display("point_transform_perspective_divide_unit_tb: PASS");
      else
         $display("point_transform_perspective_divide_unit_tb: FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/ptpd_pkg.sv
rtl/ptpd_matrix_mem.sv
rtl/ptpd_dot_engine.sv
rtl/ptpd_divider.sv
rtl/point_transform_perspective_divide_unit.sv
sim/point_transform_perspective_divide_unit_tb.sv
